// ===== design/ile_pkg.sv =====
package ile_pkg;

   localparam int CAPACITY    = 256;
   localparam int POS_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int OP_W        = 3;
   localparam int IDX_W       = 9;
   localparam int DATA_W      = 32;
   localparam int ST_W        = 2;
   localparam int LEN_W       = 9;
   localparam int CMP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;
   localparam int GROUP_SIZE  = 16;
   localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   typedef enum logic [OP_W-1:0] {
      OP_GET      = 3'd0,
      OP_INS_HEAD = 3'd1,
      OP_INS_TAIL = 3'd2,
      OP_INS_AT   = 3'd3,
      OP_DELETE   = 3'd4
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_FETCH,
      RD_MISS
   } rd_mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_GROUP,
      S_SUM,
      S_FINISH
   } state_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic              load;
      logic              ins;
      logic              del;
      logic              rd;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// ===== design/ile_cell.sv =====
module ile_cell (
   input  logic                         clock,
   input  ile_pkg::cell_cmd_type        cmd,
   input  logic [ile_pkg::POS_W-1:0]    pos,
   input  logic [ile_pkg::DATA_W-1:0]   left_entry,
   input  logic [ile_pkg::DATA_W-1:0]   right_entry,
   output logic [ile_pkg::DATA_W-1:0]   entry,
   output logic [ile_pkg::DATA_W-1:0]   tap
);
   import ile_pkg::*;

   logic [DATA_W-1:0] entry_ff, entry_in;
   logic [DATA_W-1:0] tap_ff, tap_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.load && cmd.ins) begin
         if (pos == cmd.pos) begin
            entry_in = cmd.value;
         end else if (pos > cmd.pos) begin
            entry_in = left_entry;
         end
      end
      // close the gap: take the neighbour above
      if (cmd.load && cmd.del && (pos >= cmd.pos)) begin
         entry_in = right_entry;
      end
   end

   always_comb begin
      tap_in = tap_ff;
      if (cmd.load) begin
         tap_in = (cmd.rd && (pos == cmd.pos)) ? entry_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      tap_ff   <= tap_in;
   end

   assign entry = entry_ff;
   assign tap   = tap_ff;

endmodule

// ===== design/ile_fold.sv =====
module ile_fold (
   input  logic                       clock,
   input  logic [ile_pkg::DATA_W-1:0] taps [ile_pkg::CAPACITY],
   output logic [ile_pkg::DATA_W-1:0] sum
);
   import ile_pkg::*;

   logic [DATA_W-1:0] group_ff [NUM_GROUPS];
   logic [DATA_W-1:0] group_in [NUM_GROUPS];
   logic [DATA_W-1:0] sum_ff, sum_in;

   // only the selected cell drives a non-zero tap, so OR merges them
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < CAPACITY) begin
               group_in[g] = group_in[g] | taps[g * GROUP_SIZE + j];
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         sum_in = sum_in | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      sum_ff   <= sum_in;
   end

   assign sum = sum_ff;

endmodule

// ===== design/ile_ctrl.sv =====
module ile_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ile_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ile_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output ile_pkg::cell_cmd_type           cmd,
   input  logic [ile_pkg::DATA_W-1:0]      sum
);
   import ile_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              ins_ff, ins_in;
   logic              del_ff, del_in;
   logic              rd_ff, rd_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] value_ff, value_in;
   status_type        status_ff, status_in;
   rd_mode_type       rd_mode_ff, rd_mode_in;

   logic              accept;
   logic              finish_go;
   op_type            op;
   logic [CMP_W-1:0]  idx_x;
   logic [CMP_W-1:0]  cnt_x;
   logic [CMP_W-1:0]  ins_x;
   logic [DATA_W-1:0] read_value;

   assign op    = op_type'(req_tdata[2:0]);
   assign idx_x = CMP_W'(req_tdata[11:3]);
   assign cnt_x = CMP_W'(count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (accept) state_in = S_EXEC;
         S_EXEC:   state_in = S_GROUP;
         S_GROUP:  state_in = S_SUM;
         S_SUM:    state_in = S_FINISH;
         S_FINISH: if (finish_go) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      finish_go  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);
   end

   assign accept = req_tvalid && req_tready;

   // decode the item against the current length
   always_comb begin
      ins_in     = 1'b0;
      del_in     = 1'b0;
      rd_in      = 1'b0;
      status_in  = ST_DONE;
      rd_mode_in = RD_ZERO;
      count_in   = count_ff;
      ins_x      = idx_x;
      case (op)
         OP_GET: begin
            if (idx_x < cnt_x) begin
               rd_in      = 1'b1;
               rd_mode_in = RD_FETCH;
            end else begin
               status_in  = ST_RANGE;
               rd_mode_in = RD_MISS;
            end
         end
         OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
            if (op == OP_INS_HEAD) begin
               ins_x = '0;
            end else if (op == OP_INS_TAIL) begin
               ins_x = cnt_x;
            end
            if (ins_x > cnt_x) begin
               status_in = ST_RANGE;
            end else if (cnt_x >= CMP_W'(CAPACITY)) begin
               status_in = ST_FULL;
            end else begin
               ins_in   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_DELETE: begin
            if (idx_x < cnt_x) begin
               del_in   = 1'b1;
               count_in = count_ff - 1'b1;
            end else begin
               status_in = ST_RANGE;
            end
         end
         default: status_in = ST_RANGE;
      endcase
      pos_in   = ins_x[POS_W-1:0];
      value_in = req_tdata[43:12];
   end

   always_comb begin
      cmd.load  = (state_ff == S_EXEC);
      cmd.ins   = ins_ff;
      cmd.del   = del_ff;
      cmd.rd    = rd_ff;
      cmd.pos   = pos_ff;
      cmd.value = value_ff;
   end

   always_comb begin
      case (rd_mode_ff)
         RD_FETCH: read_value = sum;
         RD_MISS:  read_value = '1;
         default:  read_value = '0;
      endcase
   end

   // fields: status [1:0], read_value [33:2], length [42:34]
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_TDATA_W'({LEN_W'(count_ff), read_value, status_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ins_ff       <= 1'b0;
         del_ff       <= 1'b0;
         rd_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
            ins_ff   <= ins_in;
            del_ff   <= del_in;
            rd_ff    <= rd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         pos_ff     <= pos_in;
         value_ff   <= value_in;
         status_ff  <= status_in;
         rd_mode_ff <= rd_mode_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/indexed_list_engine_unit.sv =====
// Indexed list engine: an ordered list of up to CAPACITY signed 32-bit
// values held in a chain of cells, one value per cell. Insert opens a gap
// by moving every later cell's value one place up, all in the same cycle;
// delete closes it by moving them one place down. Get selects the cell at
// the index and merges the cells' outputs through a two-level registered
// OR tree. Each item is handled one at a time: it is accepted, the chain
// acts on it in the next cycle, the tree's group and sum registers follow,
// and the result is then placed in the output register; only then, and
// only once the output register has room, is the next item accepted. The
// output register lets the next item enter while an earlier result still
// waits. Every item gives one result with the status, the value read and
// the length after the operation.
module indexed_list_engine_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // operation [2:0], index [11:3], value [43:12], zeros above
   input  logic [ile_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status [1:0], read_value [33:2], length [42:34], zeros above
   output logic [ile_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ile_pkg::*;

   cell_cmd_type      cmd;
   logic [DATA_W-1:0] sum;
   logic [DATA_W-1:0] entries [CAPACITY];
   logic [DATA_W-1:0] taps    [CAPACITY];

   ile_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sum        (sum)
   );

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [DATA_W-1:0] left_entry;
      logic [DATA_W-1:0] right_entry;

      if (k == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_mid_l
         assign left_entry = entries[k-1];
      end

      if (k == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_mid_r
         assign right_entry = entries[k+1];
      end

      ile_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .pos         (POS_W'(k)),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entries[k]),
         .tap         (taps[k])
      );
   end

   ile_fold u_fold (
      .clock (clock),
      .taps  (taps),
      .sum   (sum)
   );

endmodule

// ===== tb/sv/indexed_list_engine_unit_test.sv =====
`timescale 1ns / 100ps

module indexed_list_engine_unit_test;
   import ile_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   localparam int ITEM_TOTAL   = 1550;
   localparam int LONG_HOLD    = 300;
   localparam int IDLE_LIMIT   = 3000;
   localparam int SETTLE_TICKS = 20;

   typedef enum {PH_MIX, PH_FILL, PH_DRAIN} phase_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] read_value;
      logic [LEN_W-1:0]  length;
   } reply_type;

   // Mirror of the list contents; predicts the reply of every accepted item.
   class list_shadow;
      logic [DATA_W-1:0] cells [CAPACITY];
      int                count;
      reply_type         awaited [$];
      int                failures;

      function new();
         count    = 0;
         failures = 0;
      endfunction

      function void apply_request(logic [REQ_TDATA_W-1:0] word);
         logic [OP_W-1:0]   op;
         logic [IDX_W-1:0]  idx;
         logic [DATA_W-1:0] val;
         reply_type         rep;
         int                pos;
         op  = word[2:0];
         idx = word[11:3];
         val = word[43:12];
         rep.status     = ST_DONE;
         rep.read_value = '0;
         case (op)
            OP_GET: begin
               if (idx < count) begin
                  rep.read_value = cells[idx[POS_W-1:0]];
               end else begin
                  rep.status     = ST_RANGE;
                  rep.read_value = '1;
               end
            end
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
               if (op == OP_INS_HEAD) pos = 0;
               else if (op == OP_INS_TAIL) pos = count;
               else pos = int'(idx);
               // range check takes precedence over the full check
               if (pos > count) begin
                  rep.status = ST_RANGE;
               end else if (count >= CAPACITY) begin
                  rep.status = ST_FULL;
               end else begin
                  for (int i = count; i > pos; i--) cells[i] = cells[i-1];
                  cells[pos] = val;
                  count++;
               end
            end
            OP_DELETE: begin
               if (idx < count) begin
                  for (int i = int'(idx); i < count - 1; i++) cells[i] = cells[i+1];
                  count--;
               end else begin
                  rep.status = ST_RANGE;
               end
            end
            default: rep.status = ST_RANGE;
         endcase
         rep.length = count[LEN_W-1:0];
         awaited.push_back(rep);
      endfunction

      function void check_reply(logic [RSP_TDATA_W-1:0] word);
         reply_type want;
         if (awaited.size() == 0) begin
            failures++;
            $display("%0t: reply with none pending, expected none, actual %h", $time, word);
            return;
         end
         want = awaited.pop_front();
         if (word[1:0] !== want.status) begin
            failures++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, word[1:0]);
         end
         if (word[33:2] !== want.read_value) begin
            failures++;
            $display("%0t: read_value mismatch, expected %h, actual %h",
                     $time, want.read_value, word[33:2]);
         end
         if (word[42:34] !== want.length) begin
            failures++;
            $display("%0t: length mismatch, expected %0d, actual %0d",
                     $time, want.length, word[42:34]);
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   list_shadow shadow = new();
   int         items_sent = 0;
   int         idle_cycles = 0;

   indexed_list_engine_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic logic [REQ_TDATA_W-1:0] pack_item(logic [OP_W-1:0] op,
                                                         logic [IDX_W-1:0] idx,
                                                         logic [DATA_W-1:0] val);
      return {4'b0, val, idx, op};
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] make_item(phase_type ph, int len);
      int                r;
      int                s;
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] val;
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 2);
      case (ph)
         PH_FILL: begin
            if (r < 25) op = OP_INS_HEAD;
            else if (r < 50) op = OP_INS_TAIL;
            else if (r < 75) op = OP_INS_AT;
            else if (r < 85) op = OP_GET;
            else if (r < 95) op = OP_DELETE;
            else op = (s == 0) ? OP_SPARE_5 : (s == 1) ? OP_SPARE_6 : OP_SPARE_7;
         end
         PH_DRAIN: begin
            if (r < 60) op = OP_DELETE;
            else if (r < 80) op = OP_GET;
            else if (r < 85) op = OP_INS_HEAD;
            else if (r < 90) op = OP_INS_TAIL;
            else if (r < 95) op = OP_INS_AT;
            else op = (s == 0) ? OP_SPARE_5 : (s == 1) ? OP_SPARE_6 : OP_SPARE_7;
         end
         default: begin
            if (r < 25) op = OP_GET;
            else if (r < 40) op = OP_INS_HEAD;
            else if (r < 52) op = OP_INS_TAIL;
            else if (r < 70) op = OP_INS_AT;
            else if (r < 95) op = OP_DELETE;
            else op = (s == 0) ? OP_SPARE_5 : (s == 1) ? OP_SPARE_6 : OP_SPARE_7;
         end
      endcase
      r = $urandom_range(0, 99);
      if (r < 60) idx = IDX_W'($urandom_range(0, len));
      else if (r < 72) idx = IDX_W'(len);
      else if (r < 80) idx = IDX_W'(len + 1);
      else if (r < 92) idx = IDX_W'($urandom_range(0, 511));
      else idx = (s == 0) ? 9'd0 : (s == 1) ? 9'd256 : 9'd511;
      r = $urandom_range(0, 99);
      if (r < 85) val = $urandom;
      else if (r < 88) val = 32'h0000_0000;
      else if (r < 91) val = 32'h7FFF_FFFF;
      else if (r < 94) val = 32'h8000_0000;
      else if (r < 97) val = 32'hFFFF_FFFF;
      else val = 32'h0000_0001;
      return pack_item(op, idx, val);
   endfunction

   // Offer one item, hold it until taken, then note it in the mirror.
   task automatic send_item(input logic [REQ_TDATA_W-1:0] word);
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      shadow.apply_request(word);
      items_sent++;
   endtask

   task automatic rest_sender(input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic offer_random(input phase_type ph);
      send_item(make_item(ph, shadow.count));
      rest_sender(pick_gap());
   endtask

   task automatic wait_all_replies();
      while (shadow.awaited.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_reply(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : reply_sink
      int  want;
      int  gap;
      int  taken;
      bit  held;
      taken = 0;
      held  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         want = $urandom_range(1, 8);
         while (want > 0) begin
            @(posedge clock);
            if (rsp_tvalid && rsp_tready) begin
               want--;
               taken++;
            end
         end
         // one long hold-off so the block backs up and stalls its input
         if (!held && taken >= 150) begin
            held = 1'b1;
            gap  = LONG_HOLD;
         end else begin
            gap = pick_gap();
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [REQ_TDATA_W-1:0] opening [$];
      int                     n;
      int                     extra;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list: every access is out of range
      opening.push_back(pack_item(OP_GET,      9'd0,   32'h0000_0000));
      opening.push_back(pack_item(OP_DELETE,   9'd0,   32'h0000_0000));
      opening.push_back(pack_item(OP_INS_AT,   9'd1,   32'h1111_1111));
      opening.push_back(pack_item(OP_INS_AT,   9'd256, 32'h2222_2222));
      // build [-1, 0, min, max, 0x12345678]
      opening.push_back(pack_item(OP_INS_AT,   9'd0,   32'h8000_0000));
      opening.push_back(pack_item(OP_INS_TAIL, 9'd0,   32'h7FFF_FFFF));
      opening.push_back(pack_item(OP_INS_HEAD, 9'd511, 32'hFFFF_FFFF));
      opening.push_back(pack_item(OP_INS_AT,   9'd1,   32'h0000_0000));
      opening.push_back(pack_item(OP_INS_AT,   9'd4,   32'h1234_5678));
      opening.push_back(pack_item(OP_GET,      9'd0,   32'h0000_0000));
      opening.push_back(pack_item(OP_GET,      9'd2,   32'hFFFF_FFFF));
      opening.push_back(pack_item(OP_GET,      9'd4,   32'h0000_0000));
      opening.push_back(pack_item(OP_GET,      9'd5,   32'h0000_0000));
      opening.push_back(pack_item(OP_GET,      9'd511, 32'h0000_0000));
      opening.push_back(pack_item(OP_SPARE_5,  9'd0,   32'h5555_5555));
      opening.push_back(pack_item(OP_SPARE_6,  9'd3,   32'h0000_0000));
      opening.push_back(pack_item(OP_SPARE_7,  9'd511, 32'hFFFF_FFFF));
      // remove last, first, then a middle element
      opening.push_back(pack_item(OP_DELETE,   9'd4,   32'h0000_0000));
      opening.push_back(pack_item(OP_DELETE,   9'd0,   32'h0000_0000));
      opening.push_back(pack_item(OP_DELETE,   9'd1,   32'h0000_0000));
      opening.push_back(pack_item(OP_GET,      9'd1,   32'h0000_0000));
      opening.push_back(pack_item(OP_DELETE,   9'd7,   32'h0000_0000));
      opening.push_back(pack_item(OP_GET,      9'd0,   32'h0000_0000));
      opening.push_back(pack_item(OP_INS_AT,   9'd2,   32'hA5A5_A5A5));
      foreach (opening[i]) begin
         send_item(opening[i]);
         rest_sender(pick_gap());
      end

      for (n = 0; n < 250; n++) offer_random(PH_MIX);
      req_tvalid <= 1'b0;
      wait_all_replies();

      // grow to capacity, then keep pushing against the full list
      n     = 0;
      extra = 0;
      while (n < 700 && extra < 40) begin
         offer_random(PH_FILL);
         n++;
         if (shadow.count == CAPACITY) extra++;
      end

      // shrink to empty and stay there a while
      n     = 0;
      extra = 0;
      while (n < 700 && extra < 30) begin
         offer_random(PH_DRAIN);
         n++;
         if (shadow.count == 0) extra++;
      end

      while (items_sent < ITEM_TOTAL) offer_random(PH_MIX);
      req_tvalid <= 1'b0;

      wait_all_replies();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (shadow.failures == 0 && shadow.awaited.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/ile_pkg.sv
design/ile_cell.sv
design/ile_fold.sv
design/ile_ctrl.sv
design/indexed_list_engine_unit.sv
tb/sv/indexed_list_engine_unit_test.sv
